### hdl/json_string_escape_utf8_check_defines.svh
// ----------------------------------------------------------------------------
// json string escaper: assertion macros
// Concurrent check wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPE_UTF8_CHECK_DEFINES_SVH
`define JSON_STRING_ESCAPE_UTF8_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define JSEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define JSEC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JSEC_ASSERT(label, prop, msg)
`define JSEC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### hdl/jsec_pkg.sv
// ----------------------------------------------------------------------------
// jsec_pkg
// Shared types, constants and result expansion for the json string escaper.
// ----------------------------------------------------------------------------
package jsec_pkg;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // utf-8 limits
  localparam logic [20:0] MAX_CODE   = 21'h10ffff;
  localparam logic [20:0] SURR_LO    = 21'h00d800;
  localparam logic [20:0] SURR_HI    = 21'h00dfff;
  localparam logic [20:0] MAX_ONE    = 21'h00007f;
  localparam logic [20:0] MAX_TWO    = 21'h0007ff;
  localparam logic [20:0] MAX_THREE  = 21'h00ffff;
  localparam logic [7:0]  LEAD2_LO   = 8'hc2;
  localparam logic [7:0]  LEAD2_HI   = 8'hdf;
  localparam logic [7:0]  LEAD3_LO   = 8'he0;
  localparam logic [7:0]  LEAD3_HI   = 8'hef;
  localparam logic [7:0]  LEAD4_LO   = 8'hf0;
  localparam logic [7:0]  LEAD4_HI   = 8'hf4;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [7:0]  ASCII_LIM  = 8'h80;

  // what to emit for the data byte
  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_RAW  = 3'd1,
    K_ESC2 = 3'd2,
    K_ESC6 = 3'd3,
    K_ERR  = 3'd4
  } jsec_kind_t;

  // what to emit at string end
  typedef enum logic [1:0] {
    CL_NONE  = 2'd0,
    CL_QUOTE = 2'd1,
    CL_ERR   = 2'd2
  } jsec_close_t;

  // command word passed from front to back
  typedef struct packed {
    logic        open;
    jsec_kind_t  kind;
    logic [7:0]  ch;
    jsec_close_t close;
  } jsec_cmd_t;

  // one result word
  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
    logic       err;
  } jsec_res_t;

  // lower-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = {4'b0000, d} + ((d < 4'd10) ? 8'h30 : 8'h57);
  endfunction

  // results produced by the data part
  function automatic logic [2:0] kind_len(input jsec_kind_t k);
    case (k)
      K_RAW:   kind_len = 3'd1;
      K_ESC2:  kind_len = 3'd2;
      K_ESC6:  kind_len = 3'd6;
      K_ERR:   kind_len = 3'd1;
      default: kind_len = 3'd0;
    endcase
  endfunction

  // total results of one command, 0..8
  function automatic logic [3:0] res_count(input jsec_cmd_t c);
    res_count = {3'b000, c.open} + {1'b0, kind_len(c.kind)}
              + {3'b000, (c.close != CL_NONE)};
  endfunction

  // result at position idx of a command
  function automatic jsec_res_t res_at(input jsec_cmd_t c, input logic [2:0] idx);
    jsec_res_t  r;
    logic [2:0] j;
    r = '{ch: CH_NUL, eor: 1'b0, err: 1'b0};
    j = idx - {2'b00, c.open};
    if (c.open && (idx == 3'd0)) begin
      r.ch = CH_QUOTE;
    end else if (j < kind_len(c.kind)) begin
      case (c.kind)
        K_RAW: r.ch = c.ch;
        K_ESC2: r.ch = (j == 3'd0) ? CH_BSLASH : c.ch;
        K_ESC6: begin
          case (j)
            3'd0:    r.ch = CH_BSLASH;
            3'd1:    r.ch = CH_U;
            3'd4:    r.ch = hex_char(c.ch[7:4]);
            3'd5:    r.ch = hex_char(c.ch[3:0]);
            default: r.ch = CH_ZERO;
          endcase
        end
        K_ERR: begin
          r.eor = 1'b1;
          r.err = 1'b1;
        end
        default: r.ch = CH_NUL;
      endcase
    end else begin
      case (c.close)
        CL_QUOTE: begin
          r.ch  = CH_QUOTE;
          r.eor = 1'b1;
        end
        CL_ERR: begin
          r.eor = 1'b1;
          r.err = 1'b1;
        end
        default: r.ch = CH_NUL;
      endcase
    end
    res_at = r;
  endfunction

endpackage

### hdl/jsec_front.sv
// ----------------------------------------------------------------------------
// jsec_front
// Accepts input words, tracks utf-8 decode state and classifies each word
// into a command for the back end.
// ----------------------------------------------------------------------------
module jsec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_has_data,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output jsec_pkg::jsec_cmd_t q_din
);

  logic        inside_r, inside_nxt;
  logic        failed_r, failed_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  lead_r, lead_nxt;
  logic [20:0] code_r, code_nxt;

  logic        acc;
  logic        failed_e;
  logic [1:0]  pend_e, lead_e, pend_c, lead_c, pend_after;
  logic [20:0] code_e, code_c;
  logic        do_chk, chk_ok, bad;
  logic [7:0]  b;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign b        = in_data_byte;

  // state as seen by this word: a new string starts clean
  assign failed_e = inside_r ? failed_r : 1'b0;
  assign pend_e   = inside_r ? pend_r   : 2'd0;
  assign lead_e   = inside_r ? lead_r   : 2'd0;
  assign code_e   = inside_r ? code_r   : 21'd0;
  assign do_chk   = in_has_data && !failed_e;

  // utf-8 check of one byte
  always_comb begin
    chk_ok = 1'b1;
    pend_c = pend_e;
    lead_c = lead_e;
    code_c = code_e;
    if (pend_e == 2'd0) begin
      if (b < jsec_pkg::ASCII_LIM) begin
        chk_ok = 1'b1;
      end else if (b inside {[jsec_pkg::LEAD2_LO:jsec_pkg::LEAD2_HI]}) begin
        lead_c = 2'd1;
        pend_c = 2'd1;
        code_c = {16'd0, b[4:0]};
      end else if (b inside {[jsec_pkg::LEAD3_LO:jsec_pkg::LEAD3_HI]}) begin
        lead_c = 2'd2;
        pend_c = 2'd2;
        code_c = {17'd0, b[3:0]};
      end else if (b inside {[jsec_pkg::LEAD4_LO:jsec_pkg::LEAD4_HI]}) begin
        lead_c = 2'd3;
        pend_c = 2'd3;
        code_c = {18'd0, b[2:0]};
      end else begin
        chk_ok = 1'b0;
      end
    end else if (b[7:6] != 2'b10) begin
      chk_ok = 1'b0;
    end else begin
      code_c = {code_e[14:0], b[5:0]};
      pend_c = pend_e - 2'd1;
      if (pend_c == 2'd0) begin
        if ((code_c > jsec_pkg::MAX_CODE) ||
            ((code_c >= jsec_pkg::SURR_LO) && (code_c <= jsec_pkg::SURR_HI)) ||
            (code_c <= jsec_pkg::MAX_ONE) ||
            ((code_c <= jsec_pkg::MAX_TWO) && (lead_e >= 2'd2)) ||
            ((code_c <= jsec_pkg::MAX_THREE) && (lead_e == 2'd3))) begin
          chk_ok = 1'b0;
        end
      end
    end
  end

  assign bad        = do_chk && !chk_ok;
  assign pend_after = do_chk ? pend_c : pend_e;

  // classify into a command word
  always_comb begin
    q_din.open  = !inside_r;
    q_din.ch    = b;
    q_din.kind  = jsec_pkg::K_NONE;
    q_din.close = jsec_pkg::CL_NONE;
    if (do_chk) begin
      if (!chk_ok) begin
        q_din.kind = jsec_pkg::K_ERR;
      end else begin
        case (b)
          8'h22, 8'h5c: q_din.kind = jsec_pkg::K_ESC2;
          8'h08: begin q_din.kind = jsec_pkg::K_ESC2; q_din.ch = 8'h62; end
          8'h0c: begin q_din.kind = jsec_pkg::K_ESC2; q_din.ch = 8'h66; end
          8'h0a: begin q_din.kind = jsec_pkg::K_ESC2; q_din.ch = 8'h6e; end
          8'h0d: begin q_din.kind = jsec_pkg::K_ESC2; q_din.ch = 8'h72; end
          8'h09: begin q_din.kind = jsec_pkg::K_ESC2; q_din.ch = 8'h74; end
          default: begin
            q_din.kind = (b < jsec_pkg::CTRL_LIMIT) ? jsec_pkg::K_ESC6 : jsec_pkg::K_RAW;
          end
        endcase
      end
    end
    if (in_last && !failed_e && !bad) begin
      q_din.close = (pend_after != 2'd0) ? jsec_pkg::CL_ERR : jsec_pkg::CL_QUOTE;
    end
  end

  // words that produce nothing are dropped here
  assign q_push = acc && (q_din.open || (q_din.kind != jsec_pkg::K_NONE) ||
                          (q_din.close != jsec_pkg::CL_NONE));

  // decode state update
  always_comb begin
    inside_nxt = inside_r;
    failed_nxt = failed_r;
    pend_nxt   = pend_r;
    lead_nxt   = lead_r;
    code_nxt   = code_r;
    if (acc) begin
      if (in_last) begin
        inside_nxt = 1'b0;
        failed_nxt = 1'b0;
        pend_nxt   = 2'd0;
        lead_nxt   = 2'd0;
        code_nxt   = 21'd0;
      end else begin
        inside_nxt = 1'b1;
        failed_nxt = failed_e || bad;
        pend_nxt   = (do_chk && chk_ok) ? pend_c : pend_e;
        lead_nxt   = (do_chk && chk_ok) ? lead_c : lead_e;
        code_nxt   = (do_chk && chk_ok) ? code_c : code_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      failed_r <= 1'b0;
      pend_r   <= 2'd0;
      lead_r   <= 2'd0;
      code_r   <= 21'd0;
    end else begin
      inside_r <= inside_nxt;
      failed_r <= failed_nxt;
      pend_r   <= pend_nxt;
      lead_r   <= lead_nxt;
      code_r   <= code_nxt;
    end
  end

endmodule

### hdl/jsec_queue.sv
// ----------------------------------------------------------------------------
// jsec_queue
// Small command queue between front and back end, head shown directly.
// ----------------------------------------------------------------------------
module jsec_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsec_pkg::jsec_cmd_t din,
  input  logic                pop,
  output jsec_pkg::jsec_cmd_t dout,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsec_pkg::jsec_cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

### hdl/jsec_back.sv
// ----------------------------------------------------------------------------
// jsec_back
// Expands each queued command into result words, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module jsec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  jsec_pkg::jsec_cmd_t q_dout,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_end_of_run,
  output logic                out_status
);

  logic                valid_r, valid_nxt;
  logic [2:0]          step_r, step_nxt;
  jsec_pkg::jsec_res_t res_r;
  jsec_pkg::jsec_res_t res_nxt;
  logic                load, fire, at_last;

  assign load    = !valid_r || out_ready;
  assign fire    = load && !q_empty;
  assign res_nxt = jsec_pkg::res_at(q_dout, step_r);
  assign at_last = (({1'b0, step_r} + 4'd1) == jsec_pkg::res_count(q_dout));
  assign q_pop   = fire && at_last;

  // step through the results of the head command
  always_comb begin
    valid_nxt = valid_r;
    step_nxt  = step_r;
    if (load) begin
      valid_nxt = !q_empty;
    end
    if (fire) begin
      step_nxt = at_last ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = res_r.ch;
  assign out_end_of_run = res_r.eor;
  assign out_status     = res_r.err;

endmodule

### hdl/json_string_escape_utf8_check.sv
// ----------------------------------------------------------------------------
// json_string_escape_utf8_check
// Quotes and escapes a byte string as a json string while checking strict
// utf-8; a fault ends the run with an error word.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_data_byte, in_has_data, in_last
//   out      out  out_valid / out_ready  out_byte, out_end_of_run, out_status
//
// An input word makes up to 8 result words, which the back end emits one
// word per cycle while the output is not stalled. The command queue lets
// the front keep accepting while the back end expands an escape or the output
// is stalled. Synchronous active-low reset clears the decode state, the queue
// and the output stage.
// ----------------------------------------------------------------------------
`include "json_string_escape_utf8_check_defines.svh"

module json_string_escape_utf8_check #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_data,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_run,
  output logic       out_status
);

  jsec_pkg::jsec_cmd_t q_din, q_dout;
  logic                q_push, q_pop, q_full, q_empty;

  // classify
  jsec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_has_data  (in_has_data),
    .in_last      (in_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_din        (q_din)
  );

  // command queue
  jsec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // expand
  jsec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run),
    .out_status     (out_status)
  );

  // checks
  `JSEC_ASSERT_NEVER(a_push_full, q_push && q_full, "command pushed into full queue")
  `JSEC_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "command popped from empty queue")
  `JSEC_ASSERT(a_err_word, out_valid && out_status |-> out_end_of_run && out_byte == 8'h00, "error word malformed")

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: json string escaper regression
// Drives byte strings into the escaper on a valid/ready channel and checks
// every output word against a cycle-free prediction of the quoted, escaped
// text and of the strict utf-8 fault result. Both channels idle at random,
// and the output is held off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb;

  // control characters with a short escape
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0a;
  localparam logic [7:0] CTL_FF  = 8'h0c;
  localparam logic [7:0] CTL_CR  = 8'h0d;
  // letters that follow the backslash
  localparam logic [7:0] ESC_B = 8'h62;
  localparam logic [7:0] ESC_F = 8'h66;
  localparam logic [7:0] ESC_N = 8'h6e;
  localparam logic [7:0] ESC_R = 8'h72;
  localparam logic [7:0] ESC_T = 8'h74;
  localparam logic [7:0] ESC_U = 8'h75;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] LOWER_A = 8'h61;

  localparam int unsigned MAX_CYCLES   = 400000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_GAP      = 18;

  // ways a string is broken
  typedef enum logic [2:0] {
    F_OVERLONG  = 3'd0,
    F_SURROGATE = 3'd1,
    F_TOO_BIG   = 3'd2,
    F_BAD_LEAD  = 3'd3,
    F_NO_CONT   = 3'd4,
    F_TRUNCATED = 3'd5,
    F_NOISE     = 3'd6
  } utf8_fault_t;

  // one input word of a string under construction
  typedef struct packed {
    logic [7:0] b;
    logic       has;
  } str_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_has_data;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_end_of_run;
  logic       out_status;

  // predicted escaper state
  logic        open_str;
  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  logic [1:0]  seq_len;
  logic        str_bad;

  jsec_pkg::jsec_res_t json_words_due[$];
  jsec_pkg::jsec_res_t due_word;
  str_item_t           str_q[$];

  logic        send_idle;
  logic        recv_idle;
  logic        stall_request;
  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned words_checked;
  int unsigned fault_runs;
  int unsigned mismatches;
  int unsigned cycle_count;

  json_string_escape_utf8_check i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_has_data    (in_has_data),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_end_of_run (out_end_of_run),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic void push_word(input logic [7:0] ch, input logic eor, input logic err);
    jsec_pkg::jsec_res_t w;
    w.ch  = ch;
    w.eor = eor;
    w.err = err;
    json_words_due.push_back(w);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return DIGIT_0 + {4'b0000, n};
    return LOWER_A + {4'b0000, n} - 8'd10;
  endfunction

  // strict utf-8 step; 0 on a fault
  function automatic logic utf8_accept(input logic [7:0] b);
    if (cont_left == 2'd0) begin
      if (b < jsec_pkg::ASCII_LIM) return 1'b1;
      if (b >= jsec_pkg::LEAD2_LO && b <= jsec_pkg::LEAD2_HI) begin
        seq_len = 2'd1;
        cp_acc  = {16'd0, b[4:0]};
      end else if (b >= jsec_pkg::LEAD3_LO && b <= jsec_pkg::LEAD3_HI) begin
        seq_len = 2'd2;
        cp_acc  = {17'd0, b[3:0]};
      end else if (b >= jsec_pkg::LEAD4_LO && b <= jsec_pkg::LEAD4_HI) begin
        seq_len = 2'd3;
        cp_acc  = {18'd0, b[2:0]};
      end else begin
        return 1'b0;
      end
      cont_left = seq_len;
      return 1'b1;
    end
    if (b[7:6] != 2'b10) return 1'b0;
    cp_acc    = {cp_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 2'd0) return 1'b1;
    if (cp_acc > jsec_pkg::MAX_CODE) return 1'b0;
    if (cp_acc >= jsec_pkg::SURR_LO && cp_acc <= jsec_pkg::SURR_HI) return 1'b0;
    if (cp_acc <= jsec_pkg::MAX_ONE) return 1'b0;
    if (cp_acc <= jsec_pkg::MAX_TWO && seq_len >= 2'd2) return 1'b0;
    if (cp_acc <= jsec_pkg::MAX_THREE && seq_len >= 2'd3) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void escape_byte_words(input logic [7:0] b);
    logic [7:0] rep;
    case (b)
      jsec_pkg::CH_QUOTE:  rep = jsec_pkg::CH_QUOTE;
      jsec_pkg::CH_BSLASH: rep = jsec_pkg::CH_BSLASH;
      CTL_BS:              rep = ESC_B;
      CTL_FF:              rep = ESC_F;
      CTL_LF:              rep = ESC_N;
      CTL_CR:              rep = ESC_R;
      CTL_TAB:             rep = ESC_T;
      default:             rep = jsec_pkg::CH_NUL;
    endcase
    if (rep != jsec_pkg::CH_NUL) begin
      push_word(jsec_pkg::CH_BSLASH, 1'b0, 1'b0);
      push_word(rep, 1'b0, 1'b0);
    end else if (b < jsec_pkg::CTRL_LIMIT) begin
      push_word(jsec_pkg::CH_BSLASH, 1'b0, 1'b0);
      push_word(ESC_U, 1'b0, 1'b0);
      push_word(DIGIT_0, 1'b0, 1'b0);
      push_word(DIGIT_0, 1'b0, 1'b0);
      push_word(nibble_char(b[7:4]), 1'b0, 1'b0);
      push_word(nibble_char(b[3:0]), 1'b0, 1'b0);
    end else begin
      push_word(b, 1'b0, 1'b0);
    end
  endfunction

  function automatic void clear_decode();
    str_bad   = 1'b0;
    cont_left = 2'd0;
    cp_acc    = 21'd0;
    seq_len   = 2'd0;
  endfunction

  // words that one accepted input word makes
  function automatic void escape_and_check(input logic [7:0] b, input logic has,
                                           input logic fin);
    if (!open_str) begin
      open_str = 1'b1;
      clear_decode();
      push_word(jsec_pkg::CH_QUOTE, 1'b0, 1'b0);
    end
    if (has && !str_bad) begin
      if (utf8_accept(b)) begin
        escape_byte_words(b);
      end else begin
        str_bad = 1'b1;
        push_word(jsec_pkg::CH_NUL, 1'b1, 1'b1);
        fault_runs++;
      end
    end
    if (fin) begin
      if (!str_bad) begin
        if (cont_left != 2'd0) begin
          push_word(jsec_pkg::CH_NUL, 1'b1, 1'b1);
          fault_runs++;
        end else begin
          push_word(jsec_pkg::CH_QUOTE, 1'b1, 1'b0);
        end
      end
      open_str = 1'b0;
      clear_decode();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned draw_gap(input logic on);
    if (on) return $urandom_range(0, MAX_GAP);
    return 0;
  endfunction

  function automatic void pick_idle_mode();
    int unsigned m;
    m = $urandom_range(0, 3);
    send_idle = m[0];
    recv_idle = m[1];
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    str_item_t it;
    it.b   = b;
    it.has = 1'b1;
    str_q.push_back(it);
  endfunction

  function automatic void push_blank();
    str_item_t it;
    it.b   = 8'($urandom_range(0, 255));
    it.has = 1'b0;
    str_q.push_back(it);
  endfunction

  // n bytes, most significant first, from a packed word
  function automatic void push_seq(input int n, input logic [31:0] w);
    for (int i = n - 1; i >= 0; i--) push_byte(w[8*i +: 8]);
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void push_code_point(input int unsigned cp);
    if (cp < 32'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      push_byte(8'hc0 | {3'b000, cp[10:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 32'h10000) begin
      push_byte(8'he0 | {4'b0000, cp[15:12]});
      push_byte(8'h80 | {2'b00, cp[11:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end else begin
      push_byte(8'hf0 | {5'b00000, cp[20:18]});
      push_byte(8'h80 | {2'b00, cp[17:12]});
      push_byte(8'h80 | {2'b00, cp[11:6]});
      push_byte(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  // valid code point, weighted toward escapes and range edges
  function automatic int unsigned rand_code_point();
    int unsigned cp;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: cp = $urandom_range(32'h20, 32'h7f);
      4:          cp = $urandom_range(0, 32'h1f);
      5: begin
        cp = {24'd0, ($urandom_range(0, 1) != 0) ? jsec_pkg::CH_QUOTE : jsec_pkg::CH_BSLASH};
      end
      6, 7:       cp = $urandom_range(32'h80, 32'h7ff);
      8: begin
        cp = $urandom_range(32'h800, 32'hffff);
        if (cp >= 32'hd800 && cp <= 32'hdfff) cp = cp ^ 32'h2000;
      end
      9:          cp = $urandom_range(32'h10000, 32'h10ffff);
      default: begin
        case ($urandom_range(0, 7))
          0:       cp = 32'h80;
          1:       cp = 32'h7ff;
          2:       cp = 32'h800;
          3:       cp = 32'hffff;
          4:       cp = 32'h10000;
          5:       cp = 32'h10ffff;
          6:       cp = 32'hd7ff;
          default: cp = 32'he000;
        endcase
      end
    endcase
    return cp;
  endfunction

  // one input word, with a random gap before it
  task automatic send_word(input logic [7:0] b, input logic has, input logic fin);
    int unsigned gap;
    gap = draw_gap(send_idle);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_has_data  = has;
    in_last      = fin;
    do @(posedge clk); while (!in_ready);
    escape_and_check(b, has, fin);
    items_sent++;
  endtask

  // sends the built string; last rides on the final byte or on a blank end word
  task automatic send_string(input logic blank_end);
    int n;
    n = str_q.size();
    for (int i = 0; i < n; i++) begin
      send_word(str_q[i].b, str_q[i].has, (i == n - 1) && !blank_end);
    end
    if (n == 0 || blank_end) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    str_q.delete();
    strings_sent++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    // empty string
    send_string(1'b0);
    // every short escape, both \u00xx extremes and 0x7f passthrough
    push_seq(4, {jsec_pkg::CH_QUOTE, jsec_pkg::CH_BSLASH, CTL_BS, CTL_FF});
    push_seq(4, {CTL_LF, CTL_CR, CTL_TAB, 8'h00});
    push_seq(2, {16'd0, 8'h1f, 8'h7f});
    send_string(1'b0);
    // largest code point
    push_seq(4, 32'hf48fbfbf);
    send_string(1'b0);
    // surrogate, then bytes after the fault, closed by a blank word
    push_seq(4, 32'heda08041);
    send_string(1'b1);
    // truncated end
    push_seq(2, 32'h0000e282);
    send_string(1'b0);
    // bad lead at the top of the byte range
    push_byte(8'hff);
    send_string(1'b0);
    // blank word opens the string, then a lead without its continuation
    push_blank();
    push_seq(2, 32'h0000c341);
    send_string(1'b0);
  endtask

  task automatic test_wellformed_strings(input int unsigned upto);
    int unsigned len;
    while (items_sent < upto) begin
      pick_idle_mode();
      len = $urandom_range(0, 10);
      repeat (len) begin
        if ($urandom_range(0, 11) == 0) push_blank();
        push_code_point(rand_code_point());
      end
      send_string($urandom_range(0, 7) == 0);
    end
  endtask

  // output held off while escape-heavy strings keep coming
  task automatic test_output_stall();
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    stall_request = 1'b1;
    repeat (8) begin
      repeat ($urandom_range(4, 8)) begin
        if ($urandom_range(0, 3) == 0) push_code_point(rand_code_point());
        else push_byte(8'($urandom_range(0, 31)));
      end
      send_string(1'b0);
    end
  endtask

  task automatic test_broken_strings(input int unsigned upto);
    utf8_fault_t f;
    int unsigned n;
    logic [7:0]  b;
    while (items_sent < upto) begin
      pick_idle_mode();
      repeat ($urandom_range(0, 4)) push_code_point(rand_code_point());
      if ($urandom_range(0, 3) == 0) begin
        send_string($urandom_range(0, 3) == 0);
      end else begin
        f = utf8_fault_t'($urandom_range(0, 6));
        case (f)
          F_OVERLONG: begin
            if ($urandom_range(0, 1) != 0) begin
              push_byte(jsec_pkg::LEAD3_LO);
              push_byte(8'h80 + 8'($urandom_range(0, 31)));
              push_byte(rand_cont());
            end else begin
              push_byte(jsec_pkg::LEAD4_LO);
              push_byte(8'h80 + 8'($urandom_range(0, 15)));
              push_byte(rand_cont());
              push_byte(rand_cont());
            end
          end
          F_SURROGATE: begin
            push_byte(8'hed);
            push_byte(8'ha0 + 8'($urandom_range(0, 31)));
            push_byte(rand_cont());
          end
          F_TOO_BIG: begin
            push_byte(jsec_pkg::LEAD4_HI);
            push_byte(8'h90 + 8'($urandom_range(0, 47)));
            push_byte(rand_cont());
            push_byte(rand_cont());
          end
          F_BAD_LEAD: begin
            if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(8'h80, 8'hc1)));
            else push_byte(8'($urandom_range(8'hf5, 8'hff)));
          end
          F_NO_CONT, F_TRUNCATED: begin
            n = $urandom_range(1, 3);
            case (n)
              1: push_byte(8'($urandom_range(jsec_pkg::LEAD2_LO, jsec_pkg::LEAD2_HI)));
              2:       push_byte(8'($urandom_range(8'he1, 8'hec)));
              default: push_byte(8'($urandom_range(8'hf1, 8'hf3)));
            endcase
            repeat ($urandom_range(0, n - 1)) push_byte(rand_cont());
            if (f == F_NO_CONT) begin
              b = 8'($urandom_range(0, 255));
              if (b[7:6] == 2'b10) b = b ^ 8'h40;
              push_byte(b);
            end
          end
          default: repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
        endcase
        // trailing bytes after the fault
        if (f != F_TRUNCATED) begin
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 4) == 0) push_blank();
            else push_byte(8'($urandom_range(0, 255)));
          end
        end
        send_string($urandom_range(0, 3) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------- output side

  // receiver: random hold-off per word, one long hold on request
  initial begin : output_sink
    int unsigned gap;
    logic        stall_done;
    stall_done = 1'b0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (stall_request && !stall_done) begin
        gap        = LONG_HOLD;
        stall_done = 1'b1;
      end else begin
        gap = draw_gap(recv_idle);
      end
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (json_words_due.size() == 0) begin
        $error("unexpected word: out_byte %h end_of_run %b status %b",
               out_byte, out_end_of_run, out_status);
        mismatches++;
      end else begin
        due_word = json_words_due.pop_front();
        if (out_byte !== due_word.ch) begin
          $error("out_byte: expected %h, got %h", due_word.ch, out_byte);
          mismatches++;
        end
        if (out_end_of_run !== due_word.eor) begin
          $error("out_end_of_run: expected %b, got %b", due_word.eor, out_end_of_run);
          mismatches++;
        end
        if (out_status !== due_word.err) begin
          $error("out_status: expected %b, got %b", due_word.err, out_status);
          mismatches++;
        end
        words_checked++;
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still due", cycle_count,
             json_words_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main_seq
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_has_data   = 1'b0;
    in_last       = 1'b0;
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    stall_request = 1'b0;
    items_sent    = 0;
    strings_sent  = 0;
    words_checked = 0;
    fault_runs    = 0;
    mismatches    = 0;
    open_str      = 1'b0;
    clear_decode();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_wellformed_strings(280);
    test_output_stall();
    test_broken_strings(480);

    @(negedge clk);
    in_valid = 1'b0;
    while (json_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d strings in %0d input words, %0d output words checked",
             strings_sent, items_sent, words_checked);
    $display("%0d runs ended on a utf-8 fault; one long output stall filled the block",
             fault_runs);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
